FILE: hw/rtl/rlus_pkg.sv
`timescale 1ns / 1ps

package rlus_pkg;

    // Table layout: one row per architectural register, plus HI/LO-style
    // trailing entries that decode never writes.
    localparam int TABLE_ENTRIES = 34;
    localparam int NUM_REGS      = 32;
    localparam int REG_W         = 5;
    localparam int IDX_W         = 6;
    localparam int INSTR_W       = 32;
    localparam int PC_W          = 32;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [PC_W-1:0]  UNUSED_PC  = {PC_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_CONTROL,
        KIND_UNKNOWN
    } t_kind;

    // Register fields named by an instruction, and how it affects the block.
    typedef struct packed {
        logic  use_rd;
        logic  use_rt;
        logic  use_rs;
        t_kind kind;
    } t_dec;

endpackage

FILE: hw/rtl/rlus_decode.sv
`timescale 1ns / 1ps

module rlus_decode (
    input  logic [rlus_pkg::INSTR_W-1:0] i_instr,
    input  logic                         i_slot,
    output rlus_pkg::t_dec               o_dec
);
    import rlus_pkg::*;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_BEQL    = 6'd20;
    localparam logic [5:0] OP_BGTZL   = 6'd23;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LWC1    = 6'd49;
    localparam logic [5:0] OP_LLD     = 6'd52;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DMULTU  = 6'd29;
    localparam logic [5:0] FN_DDIVU   = 6'd31;
    localparam logic [5:0] FN_ALU2_LO = 6'd40;
    localparam logic [5:0] FN_ALU2_HI = 6'd47;
    localparam logic [5:0] FN_NOP_A   = 6'd1;
    localparam logic [5:0] FN_NOP_B   = 6'd5;
    localparam logic [5:0] FN_NOP_C   = 6'd10;
    localparam logic [5:0] FN_NOP_D   = 6'd11;

    localparam logic [REG_W-1:0] RS_ERET = 5'd16;
    localparam logic [5:0]       FN_ERET = 6'd24;

    logic [5:0]       op;
    logic [5:0]       fn;
    logic [REG_W-1:0] rs;

    assign op = i_instr[31:26];
    assign fn = i_instr[5:0];
    assign rs = i_instr[25:21];

    always_comb begin
        o_dec = '{use_rd: 1'b0, use_rt: 1'b0, use_rs: 1'b0, kind: KIND_PLAIN};
        priority if ((op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_BEQL && op <= OP_BGTZL)
                     || op == OP_REGIMM) begin
            o_dec.use_rs = !i_slot;
            o_dec.use_rt = !i_slot;
            o_dec.kind   = KIND_CONTROL;
        end else if (op == OP_J || op == OP_JAL) begin
            o_dec.kind = KIND_CONTROL;
        end else if (op == OP_LUI) begin
            o_dec.use_rt = 1'b1;
        end else if ((op >= OP_LB && op <= OP_LWC1) || op >= OP_LLD
                     || (op >= OP_ADDI && op <= OP_XORI)) begin
            o_dec.use_rs = 1'b1;
            o_dec.use_rt = 1'b1;
        end else if (op == OP_COP1) begin
            o_dec.kind = KIND_PLAIN;
        end else if (op == OP_COP0) begin
            // eret ends the block like an unknown word
            if (rs == RS_ERET && fn == FN_ERET) begin
                o_dec.kind = KIND_UNKNOWN;
            end
        end else if (op != OP_SPECIAL) begin
            o_dec.kind = KIND_UNKNOWN;
        end else if ((fn >= FN_ALU2_LO && fn <= FN_ALU2_HI) || fn == FN_SLLV
                     || fn == FN_SRLV || fn == FN_SRAV) begin
            o_dec.use_rd = 1'b1;
            o_dec.use_rt = 1'b1;
            o_dec.use_rs = 1'b1;
        end else if (fn == FN_SLL || fn == FN_SRL || fn == FN_SRA) begin
            // the all-zero word is a nop and names nothing
            o_dec.use_rt = (i_instr != '0);
            o_dec.use_rd = (i_instr != '0);
        end else if (fn == FN_MULTU || fn == FN_DIV || fn == FN_DMULTU
                     || fn == FN_DDIVU) begin
            o_dec.use_rt = 1'b1;
            o_dec.use_rs = 1'b1;
        end else if (fn == FN_MFLO) begin
            o_dec.use_rd = 1'b1;
            o_dec.use_rs = 1'b1;
        end else if (fn == FN_NOP_A || fn == FN_NOP_B || fn == FN_NOP_C
                     || fn == FN_NOP_D) begin
            o_dec.kind = KIND_PLAIN;
        end else if (fn == FN_JR || fn == FN_JALR) begin
            o_dec.use_rs = !i_slot;
            o_dec.kind   = KIND_CONTROL;
        end else begin
            o_dec.kind = KIND_UNKNOWN;
        end
    end

endmodule

FILE: hw/rtl/register_last_use_scanner.sv
// An instruction that does not end its block is absorbed one register write at a time
// (one write per register it names, through the single table write port).
// A block-ending beat starts a dump: one result per cycle for all 34 entries, the first
// behind S_DUMP and the read register; busy stays high until the last entry is read.
// Reset (synchronous, active low) marks every entry unused and leaves the delay slot.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module register_last_use_scanner (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rlus_pkg::INSTR_W-1:0] i_instr,
    input  logic [rlus_pkg::PC_W-1:0]    i_pc,
    input  logic                         i_fetch_fault,
    output logic                         o_strobe,
    output logic [rlus_pkg::IDX_W-1:0]   o_reg_index,
    output logic [rlus_pkg::PC_W-1:0]    o_last_use_pc,
    output logic                         o_last_entry
);
    import rlus_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_DUMP
    } t_state;

    // Mark order within one instruction: rd, rt, rs. All writes carry the
    // same data, the beat's PC, so the order never shows in the table.
    typedef struct packed {
        logic rd;
        logic rt;
        logic rs;
    } t_mask;

    // Last-use table: one row per register, written once per named register.
    logic [PC_W-1:0] mem [NUM_REGS];

    // Row valid bits stand in for the all-ones reset value, so a block end
    // or a reset clears the whole table at once.
    logic [NUM_REGS-1:0] r_valid;

    t_state           r_state;
    logic             r_in_slot;
    logic             r_end;
    t_mask            r_mask;
    logic [PC_W-1:0]  r_pc;
    logic [REG_W-1:0] r_rs;
    logic [REG_W-1:0] r_rt;
    logic [REG_W-1:0] r_rd;
    logic [IDX_W-1:0] r_idx;

    // Dump read stage: registered memory data arrives in the cycle after the address.
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_last;
    logic             r_rd_hit;
    logic [PC_W-1:0]  r_rd_data;

    t_dec             dec;
    logic             accept;
    t_mask            acc_mask;
    logic             acc_end;
    logic             acc_clear;
    logic             acc_slot;
    t_mask            cur_mask;
    t_mask            n_mask;
    logic [REG_W-1:0] cur_rs;
    logic [REG_W-1:0] cur_rt;
    logic [REG_W-1:0] cur_rd;
    logic             w_en;
    logic [REG_W-1:0] w_addr;
    logic [PC_W-1:0]  w_data;

    rlus_decode u_decode (
        .i_instr (i_instr),
        .i_slot  (r_in_slot),
        .o_dec   (dec)
    );

    assign accept = start && (r_state == S_IDLE);

    // A fault names nothing and throws the table away, slot or not.
    assign acc_mask  = i_fetch_fault ? t_mask'('0)
                                     : t_mask'{rd: dec.use_rd, rt: dec.use_rt, rs: dec.use_rs};
    // Any beat in a delay slot ends the block; unknown words end it at once.
    assign acc_end   = i_fetch_fault || r_in_slot || (dec.kind == KIND_UNKNOWN);
    // Outside a slot an unknown word drops the whole table before the dump.
    assign acc_clear = i_fetch_fault || (!r_in_slot && dec.kind == KIND_UNKNOWN);
    assign acc_slot  = !i_fetch_fault && !r_in_slot && (dec.kind == KIND_CONTROL);

    // The first register write goes out in the accept cycle itself; the rest
    // follow from the saved fields in S_MARK.
    always_comb begin
        if (r_state == S_IDLE) begin
            cur_mask = acc_mask;
            cur_rs   = i_instr[25:21];
            cur_rt   = i_instr[20:16];
            cur_rd   = i_instr[15:11];
            w_data   = i_pc;
        end else begin
            cur_mask = r_mask;
            cur_rs   = r_rs;
            cur_rt   = r_rt;
            cur_rd   = r_rd;
            w_data   = r_pc;
        end

        n_mask = cur_mask;
        priority if (cur_mask.rd) begin
            w_addr    = cur_rd;
            n_mask.rd = 1'b0;
        end else if (cur_mask.rt) begin
            w_addr    = cur_rt;
            n_mask.rt = 1'b0;
        end else begin
            w_addr    = cur_rs;
            n_mask.rs = 1'b0;
        end

        w_en = (accept || r_state == S_MARK) && (cur_mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[r_idx[REG_W-1:0]];
    end

    // Sequencer: idle/accept, remaining register writes, table dump.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_slot <= 1'b0;
            r_end     <= 1'b0;
            r_valid   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_DUMP);
            if (w_en) begin
                r_valid[w_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (accept) begin
                        if (acc_clear) begin
                            r_valid <= '0;
                        end
                        if (acc_slot) begin
                            r_in_slot <= 1'b1;
                        end
                        r_end <= acc_end;
                        if (n_mask != '0) begin
                            r_state <= S_MARK;
                        end else if (acc_end) begin
                            r_state <= S_DUMP;
                        end
                    end
                end
                S_MARK: begin
                    r_idx <= '0;
                    if (n_mask == '0) begin
                        r_state <= r_end ? S_DUMP : S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (r_idx == LAST_IDX) begin
                        // last row read this edge: drop the table, leave the slot
                        r_state   <= S_IDLE;
                        r_valid   <= '0;
                        r_in_slot <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload capture; no reset needed, the state gates every use.
    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_rd_idx  <= r_idx;
        r_rd_last <= (r_idx == LAST_IDX);
        // rows past the register file are never written and dump as unused
        r_rd_hit  <= (r_idx < IDX_W'(NUM_REGS)) && r_valid[r_idx[REG_W-1:0]];
        if (accept) begin
            r_pc <= i_pc;
            r_rs <= i_instr[25:21];
            r_rt <= i_instr[20:16];
            r_rd <= i_instr[15:11];
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_rd_vld;
    assign o_reg_index   = r_rd_idx;
    assign o_last_use_pc = r_rd_hit ? r_rd_data : UNUSED_PC;
    assign o_last_entry  = r_rd_last;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rlus_pkg::*;

    // Opcodes and function codes the decode cares about.
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_COP2    = 6'd18;
    localparam logic [5:0] OP_BEQL    = 6'd20;
    localparam logic [5:0] OP_BGTZL   = 6'd23;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LWC1    = 6'd49;
    localparam logic [5:0] OP_LWC2    = 6'd50;
    localparam logic [5:0] OP_LLD     = 6'd52;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_MOVCI   = 6'd1;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SPARE5  = 6'd5;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_MOVZ    = 6'd10;
    localparam logic [5:0] FN_MOVN    = 6'd11;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_ERET    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DMULTU  = 6'd29;
    localparam logic [5:0] FN_DDIVU   = 6'd31;
    localparam logic [5:0] FN_ALU2_LO = 6'd40;
    localparam logic [5:0] FN_ALU2_HI = 6'd47;
    localparam logic [5:0] FN_UNDEF   = 6'd63;
    localparam logic [4:0] RS_ERET    = 5'd16;

    localparam int RANDOM_BEATS = 430;
    // Longest correct silence is a sender gap plus a three-write absorb; allow far more.
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [PC_W-1:0]  pc;
        logic             is_last;
    } t_dump_entry;

    // Scoreboard: own copy of the last-use table and the delay-slot flag,
    // plus the dump entries still owed by the block.
    class last_use_board;
        logic [PC_W-1:0] use_pc [TABLE_ENTRIES];
        bit              slot_open;
        t_dump_entry     pending_dump [$];
        int              errors;

        function new();
            wipe();
            slot_open = 1'b0;
            errors    = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                use_pc[i] = UNUSED_PC;
        endfunction

        function void emit_dump();
            t_dump_entry e;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                e.idx     = IDX_W'(i);
                e.pc      = use_pc[i];
                e.is_last = (i == TABLE_ENTRIES - 1);
                pending_dump.push_back(e);
            end
            wipe();
            slot_open = 1'b0;
        endfunction

        // Which register fields a word names, and how it affects the block.
        function t_dec decode_word(logic [INSTR_W-1:0] w);
            t_dec       d;
            logic [5:0] op;
            logic [5:0] fn;
            logic [4:0] rs;
            op     = w[31:26];
            fn     = w[5:0];
            rs     = w[25:21];
            d      = '0;
            d.kind = KIND_PLAIN;
            if ((op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_BEQL && op <= OP_BGTZL)
                || op == OP_REGIMM) begin
                d.use_rs = 1'b1;
                d.use_rt = 1'b1;
                d.kind   = KIND_CONTROL;
            end else if (op == OP_J || op == OP_JAL) begin
                d.kind = KIND_CONTROL;
            end else if (op == OP_LUI) begin
                d.use_rt = 1'b1;
            end else if ((op >= OP_LB && op <= OP_LWC1) || op >= OP_LLD
                         || (op >= OP_ADDI && op <= OP_XORI)) begin
                d.use_rs = 1'b1;
                d.use_rt = 1'b1;
            end else if (op == OP_COP1) begin
                d.kind = KIND_PLAIN;
            end else if (op == OP_COP0) begin
                if (rs == RS_ERET && fn == FN_ERET)
                    d.kind = KIND_UNKNOWN;
            end else if (op != OP_SPECIAL) begin
                d.kind = KIND_UNKNOWN;
            end else if ((fn >= FN_ALU2_LO && fn <= FN_ALU2_HI) || fn == FN_SLLV
                         || fn == FN_SRLV || fn == FN_SRAV) begin
                d.use_rd = 1'b1;
                d.use_rt = 1'b1;
                d.use_rs = 1'b1;
            end else if (fn == FN_SLL || fn == FN_SRL || fn == FN_SRA) begin
                // the all-zero word is a nop and names nothing
                if (w != '0) begin
                    d.use_rt = 1'b1;
                    d.use_rd = 1'b1;
                end
            end else if (fn == FN_MULTU || fn == FN_DIV || fn == FN_DMULTU
                         || fn == FN_DDIVU) begin
                d.use_rt = 1'b1;
                d.use_rs = 1'b1;
            end else if (fn == FN_MFLO) begin
                d.use_rd = 1'b1;
                d.use_rs = 1'b1;
            end else if (fn == FN_MOVCI || fn == FN_SPARE5 || fn == FN_MOVZ
                         || fn == FN_MOVN) begin
                d.kind = KIND_PLAIN;
            end else if (fn == FN_JR || fn == FN_JALR) begin
                d.use_rs = 1'b1;
                d.kind   = KIND_CONTROL;
            end else begin
                d.kind = KIND_UNKNOWN;
            end
            return d;
        endfunction

        // Advance the table by one accepted instruction beat.
        function void note_beat(logic [INSTR_W-1:0] w, logic [PC_W-1:0] a, logic fault);
            t_dec d;
            if (fault) begin
                wipe();
                emit_dump();
                return;
            end
            d = decode_word(w);
            // a control transfer sitting in a delay slot records nothing
            if (!(slot_open && d.kind == KIND_CONTROL)) begin
                if (d.use_rd) use_pc[w[15:11]] = a;
                if (d.use_rt) use_pc[w[20:16]] = a;
                if (d.use_rs) use_pc[w[25:21]] = a;
            end
            if (slot_open) begin
                emit_dump();
            end else if (d.kind == KIND_UNKNOWN) begin
                wipe();
                emit_dump();
            end else if (d.kind == KIND_CONTROL) begin
                slot_open = 1'b1;
            end
        endfunction

        function void check_entry(logic [IDX_W-1:0] idx, logic [PC_W-1:0] pc, logic is_last);
            t_dump_entry e;
            if (pending_dump.size() == 0) begin
                $display("%0t: unexpected entry: expected none, got idx %0d pc %h last %b",
                         $time, idx, pc, is_last);
                errors++;
                return;
            end
            e = pending_dump.pop_front();
            if (idx !== e.idx) begin
                $display("%0t: reg_index: expected %0d, got %0d", $time, e.idx, idx);
                errors++;
            end
            if (pc !== e.pc) begin
                $display("%0t: last_use_pc of entry %0d: expected %h, got %h",
                         $time, e.idx, e.pc, pc);
                errors++;
            end
            if (is_last !== e.is_last) begin
                $display("%0t: last_entry of entry %0d: expected %b, got %b",
                         $time, e.idx, e.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [INSTR_W-1:0]   i_instr       = '0;
    logic [PC_W-1:0]      i_pc          = '0;
    logic                 i_fetch_fault = 1'b0;
    logic                 o_strobe;
    logic [IDX_W-1:0]     o_reg_index;
    logic [PC_W-1:0]      o_last_use_pc;
    logic                 o_last_entry;

    last_use_board board;
    logic [PC_W-1:0] next_pc;
    int              beats_sent   = 0;
    int              burst_left   = 0;
    int              quiet_cycles = 0;

    register_last_use_scanner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_instr       (i_instr),
        .i_pc          (i_pc),
        .i_fetch_fault (i_fetch_fault),
        .o_strobe      (o_strobe),
        .o_reg_index   (o_reg_index),
        .o_last_use_pc (o_last_use_pc),
        .o_last_entry  (o_last_entry)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sample both handshakes at the edge, on pre-edge values. Dump entries
    // are checked before a new beat is noted so old results stay in front.
    // The watchdog counts edges at which neither side moved anything.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                board.check_entry(o_reg_index, o_last_use_pc, o_last_entry);
            if (start && !busy)
                board.note_beat(i_instr, i_pc, i_fetch_fault);
            if (o_strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [INSTR_W-1:0] r_type(logic [4:0] rs, logic [4:0] rt,
                                                  logic [4:0] rd, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [INSTR_W-1:0] i_type(logic [5:0] op, logic [4:0] rs,
                                                  logic [4:0] rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Draw a random word of the wanted kind; bias toward the rarer encodings
    // (special jumps, eret, the nop) and reject anything of another kind.
    function automatic logic [INSTR_W-1:0] pick_word(t_kind want);
        logic [INSTR_W-1:0] w;
        t_dec               d;
        do begin
            w = $urandom;
            case (want)
                KIND_PLAIN: begin
                    if ($urandom_range(0, 15) == 0)
                        w = '0;
                    else if ($urandom_range(0, 3) == 0)
                        w[31:26] = OP_SPECIAL;
                end
                KIND_CONTROL: begin
                    if ($urandom_range(0, 3) == 0) begin
                        w[31:26] = OP_SPECIAL;
                        w[5:0]   = $urandom_range(0, 1) ? FN_JR : FN_JALR;
                    end
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        w[31:26] = OP_COP0;
                        w[25:21] = RS_ERET;
                        w[5:0]   = FN_ERET;
                    end else if ($urandom_range(0, 2) == 0) begin
                        w[31:26] = OP_SPECIAL;
                    end
                end
            endcase
            d = board.decode_word(w);
        end while (d.kind != want);
        return w;
    endfunction

    // Offer one beat and hold it until accepted; then either keep the burst
    // going or drop start for a random gap.
    task automatic send_word(input logic [INSTR_W-1:0] w, input logic fault);
        start         <= 1'b1;
        i_instr       <= w;
        i_pc          <= next_pc;
        i_fetch_fault <= fault;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        next_pc = next_pc + 32'd4;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic directed_beats();
        next_pc = 32'h0000_0000;
        // every decode group, with register fields at both ends
        send_word(i_type(OP_ADDI, 5'd31, 5'd0, 16'hffff), 1'b0);
        send_word(i_type(OP_LUI, 5'd0, 5'd31, 16'h8000), 1'b0);
        send_word(i_type(OP_LB, 5'd1, 5'd2, 16'h0004), 1'b0);
        send_word(i_type(OP_LWC1, 5'd3, 5'd4, 16'h0000), 1'b0);
        send_word(i_type(OP_LLD, 5'd5, 5'd6, 16'h7ffc), 1'b0);
        send_word(i_type(OP_COP1, 5'd7, 5'd8, 16'h1234), 1'b0);
        send_word(i_type(OP_COP0, 5'd4, 5'd9, 16'h5000), 1'b0);
        send_word('0, 1'b0);
        send_word(r_type(5'd0, 5'd3, 5'd4, FN_SLL), 1'b0);
        send_word(r_type(5'd9, 5'd8, 5'd7, FN_SLLV), 1'b0);
        send_word(r_type(5'd11, 5'd12, 5'd13, FN_ALU2_HI), 1'b0);
        send_word(r_type(5'd14, 5'd15, 5'd0, FN_MULTU), 1'b0);
        send_word(r_type(5'd16, 5'd0, 5'd17, FN_MFLO), 1'b0);
        send_word(r_type(5'd18, 5'd19, 5'd20, FN_MOVZ), 1'b0);
        // branch with a plain delay slot at the top of the address space
        next_pc = 32'hffff_fff8;
        send_word(i_type(OP_BEQ, 5'd21, 5'd22, 16'h0010), 1'b0);
        send_word(i_type(OP_ADDI, 5'd23, 5'd24, 16'h0001), 1'b0);
        // jump whose delay slot holds another jump: slot records nothing
        send_word({OP_J, 26'h3ff_ffff}, 1'b0);
        send_word(r_type(5'd25, 5'd0, 5'd0, FN_JR), 1'b0);
        // regimm with an unknown word in the slot: table kept
        send_word(i_type(OP_REGIMM, 5'd26, 5'd27, 16'h0000), 1'b0);
        send_word(i_type(OP_COP2, 5'd1, 5'd2, 16'h0003), 1'b0);
        // fault inside a delay slot
        send_word(r_type(5'd28, 5'd0, 5'd31, FN_JALR), 1'b0);
        send_word('0, 1'b1);
        // unknown outside a slot wipes recorded uses
        send_word(i_type(OP_ADDI, 5'd29, 5'd30, 16'h0000), 1'b0);
        send_word(i_type(OP_LWC2, 5'd1, 5'd2, 16'h0000), 1'b0);
        send_word(i_type(OP_XORI, 5'd1, 5'd2, 16'h00ff), 1'b0);
        send_word({OP_COP0, RS_ERET, 15'd0, 5'd0, FN_ERET}, 1'b0);
        send_word(r_type(5'd1, 5'd2, 5'd3, FN_UNDEF), 1'b0);
        // fault outside a slot, with the address all ones
        send_word(i_type(OP_ADDI, 5'd10, 5'd11, 16'h0000), 1'b0);
        next_pc = 32'hffff_ffff;
        send_word(32'hffff_ffff, 1'b1);
    endtask

    // One basic block: a run of plain words with a little noise, then a
    // random ending (control plus slot, unknown, fault, or none at all).
    task automatic random_block();
        int n;
        int r;
        int s;
        if ($urandom_range(0, 9) == 0)
            next_pc = $urandom_range(0, 1) ? 32'hffff_fff0 : 32'h0000_0000;
        else
            next_pc = $urandom;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        repeat (n) begin
            if ($urandom_range(0, 24) == 0)
                send_word($urandom, 1'b0);
            else if ($urandom_range(0, 59) == 0)
                send_word($urandom, 1'b1);
            else
                send_word(pick_word(KIND_PLAIN), 1'b0);
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            send_word(pick_word(KIND_CONTROL), 1'b0);
            s = $urandom_range(0, 19);
            if (s < 12)
                send_word(pick_word(KIND_PLAIN), 1'b0);
            else if (s < 15)
                send_word(pick_word(KIND_CONTROL), 1'b0);
            else if (s < 18)
                send_word(pick_word(KIND_UNKNOWN), 1'b0);
            else
                send_word($urandom, 1'b1);
        end else if (r < 75) begin
            send_word(pick_word(KIND_UNKNOWN), 1'b0);
        end else if (r < 85) begin
            send_word($urandom, 1'b1);
        end
    endtask

    initial begin
        int goal;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 20);
        directed_beats();
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal)
            random_block();
        // flush whatever the last block recorded
        send_word($urandom, 1'b1);
        start <= 1'b0;
        while (board.pending_dump.size() != 0)
            @(posedge i_clk);
        // drain: catch any stray entries after the last expected one
        repeat (50) @(posedge i_clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
